FILE: hdl/lkvc_pkg.sv
// shared types and constants of the lru key-value cache
`timescale 1ns / 1ps
package lkvc_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_en;
		logic decide;
		logic upd_en;
		logic load_out;
	} lkvc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pass_done;
		logic need_update;
		logic out_free;
	} lkvc_sts_t;

endpackage

FILE: hdl/lkvc_if.sv
// request and response channel interfaces of the lru key-value cache
`timescale 1ns / 1ps
interface lkvc_req_if import lkvc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic signed [KEY_W-1:0]  lookup_key;
	logic signed [DATA_W-1:0] store_value;

	modport source (output valid, opcode, lookup_key, store_value, input ready);
	modport sink (input valid, opcode, lookup_key, store_value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink (input valid, hit, read_value, output ready);
endinterface

FILE: hdl/lkvc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lkvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/lkvc_ctrl.sv
// sequencing state machine of the lru key-value cache
`timescale 1ns / 1ps
module lkvc_ctrl import lkvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      in_ready,
	input  lkvc_sts_t sts,
	output lkvc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.pass_done) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= sts.need_update ? ST_UPDATE : ST_DONE;
				end
				ST_UPDATE: begin
					if (sts.pass_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == ST_IDLE) && req_valid;
		cmd.scan_en  = (state_q == ST_SCAN);
		cmd.decide   = (state_q == ST_DECIDE);
		cmd.upd_en   = (state_q == ST_UPDATE);
		cmd.load_out = (state_q == ST_DONE) && sts.out_free;
	end

endmodule

FILE: hdl/lkvc_datapath.sv
// entry scan, lru bookkeeping and result register of the lru key-value cache
`timescale 1ns / 1ps
module lkvc_datapath import lkvc_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lkvc_cmd_t                cmd,
	output lkvc_sts_t                sts,
	input  logic [CAP_W-1:0]         cap,
	input  logic                     req_opcode,
	input  logic signed [KEY_W-1:0]  req_key,
	input  logic signed [DATA_W-1:0] req_value,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic                     out_hit,
	output logic signed [DATA_W-1:0] out_value
);

	localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int RW   = IW;
	localparam int EW   = KEY_W + DATA_W + RW;
	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [CW-1:0] LAST = CW'(MAX_ENTRIES);

	// request
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] val_q;

	// pass sequencing
	logic [CW-1:0] cnt_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          issue;
	logic [IW-1:0] raddr;

	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CW-1:0]          occ_q;

	// scan trackers
	logic              match_q, free_q, worst_q;
	logic [IW-1:0]     match_idx_q, free_idx_q, worst_idx_q;
	logic [RW-1:0]     match_rank_q, worst_rank_q;
	logic [DATA_W-1:0] match_data_q;

	// update pass
	logic [IW-1:0]     tgt_q;
	logic [RW-1:0]     old_q;
	logic              all_q;
	logic [DATA_W-1:0] wdata_q;

	logic              res_hit_q;
	logic [DATA_W-1:0] res_val_q;
	logic              out_valid_q, out_hit_q;
	logic [DATA_W-1:0] out_val_q;

	// ram port
	logic [EW-1:0]     rdata, ram_wdata;
	logic              ram_we;
	logic [KEY_W-1:0]  r_key;
	logic [DATA_W-1:0] r_data;
	logic [RW-1:0]     r_rank;
	logic              v_s1, is_tgt;

	// decision
	logic [CAP_W-1:0]  cap_f;
	logic              room;
	logic              d_upd, d_all, d_ins;
	logic [IW-1:0]     d_tgt;
	logic [RW-1:0]     d_old;
	logic [DATA_W-1:0] d_data;

	assign issue  = (cmd.scan_en || cmd.upd_en) && (cnt_q != LAST);
	assign raddr  = cnt_q[IW-1:0];
	assign r_key  = rdata[EW-1 -: KEY_W];
	assign r_data = rdata[RW +: DATA_W];
	assign r_rank = rdata[RW-1:0];
	assign v_s1   = valid_q[idx_s1];
	assign is_tgt = (idx_s1 == tgt_q);

	lkvc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_s1),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	// promote: target gets rank 0, more recent valid entries age by one
	assign ram_we = cmd.upd_en && vld_s1 &&
		(is_tgt || (v_s1 && (all_q || (r_rank < old_q))));
	assign ram_wdata = is_tgt ? {key_q, wdata_q, RW'(0)} :
		{r_key, r_data, r_rank + RW'(1)};

	// zero capacity acts as one, oversized capacity saturates through occ_q != LAST
	assign cap_f = (cap == '0) ? CAP_W'(1) : cap;
	assign room  = (occ_q != LAST) && (CMPW'(occ_q) < CMPW'(cap_f));

	always_comb begin
		d_upd  = 1'b0;
		d_all  = 1'b0;
		d_ins  = 1'b0;
		d_tgt  = match_idx_q;
		d_old  = match_rank_q;
		d_data = (op_q == OP_PUT) ? val_q : match_data_q;
		priority if (match_q) begin
			d_upd = 1'b1;
		end else if (op_q == OP_PUT && room && free_q) begin
			d_upd = 1'b1;
			d_all = 1'b1;
			d_ins = 1'b1;
			d_tgt = free_idx_q;
		end else if (op_q == OP_PUT && worst_q) begin
			d_upd = 1'b1;
			d_tgt = worst_idx_q;
			d_old = worst_rank_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			valid_q     <= '0;
			occ_q       <= '0;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			worst_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (cmd.accept || cmd.decide) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.accept) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
				worst_q <= 1'b0;
			end else if (cmd.scan_en && vld_s1) begin
				if (v_s1 && r_key == key_q && !match_q) match_q <= 1'b1;
				if (!v_s1) free_q <= 1'b1;
				if (v_s1) worst_q <= 1'b1;
			end
			if (cmd.decide && d_ins) begin
				valid_q[free_idx_q] <= 1'b1;
				occ_q               <= occ_q + CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
		if (cmd.accept) begin
			op_q  <= req_opcode;
			key_q <= req_key;
			val_q <= req_value;
		end
		if (cmd.scan_en && vld_s1) begin
			if (v_s1 && r_key == key_q && !match_q) begin
				match_idx_q  <= idx_s1;
				match_rank_q <= r_rank;
				match_data_q <= r_data;
			end
			if (!v_s1 && !free_q) free_idx_q <= idx_s1;
			if (v_s1 && (!worst_q || r_rank > worst_rank_q)) begin
				worst_idx_q  <= idx_s1;
				worst_rank_q <= r_rank;
			end
		end
		if (cmd.decide) begin
			tgt_q     <= d_tgt;
			old_q     <= d_old;
			all_q     <= d_all;
			wdata_q   <= d_data;
			res_hit_q <= match_q;
			res_val_q <= (op_q == OP_GET && match_q) ? match_data_q : '0;
		end
		if (cmd.load_out) begin
			out_hit_q <= res_hit_q;
			out_val_q <= res_val_q;
		end
	end

	assign sts.pass_done   = (cnt_q == LAST) && !vld_s1;
	assign sts.need_update = d_upd;
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_value = out_val_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy out of step with valid bits");

	a_decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> $past(sts.pass_done))
		else $error("decision taken before the scan finished");

	a_trackers_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(match_q |-> valid_q[match_idx_q]) and (worst_q |-> valid_q[worst_idx_q]))
		else $error("tracked entry is not valid");

endmodule

FILE: hdl/lru_key_value_cache_core.sv
// top level of the lru key-value cache
`timescale 1ns / 1ps
//
// channel   direction  handshake           payload
// req       in         req.valid/ready     opcode, lookup_key, store_value
// rsp       out        rsp.valid/ready     hit, read_value
// cfg       in         cfg_we (no ready)   cfg_wdata = capacity_in_use
//
// one request at a time: accept, a scan pass through the single entry ram, a
// decision step, an update pass for hits and puts, then a load of the response
// register; a get miss skips the update pass.
// reset clears valid bits, occupancy and capacity (to 16); no clearing pass.
// a waiting response lets the next request in; a stalled rsp holds the last cycle.
//
module lru_key_value_cache_core import lkvc_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	lkvc_req_if.sink         req,
	lkvc_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	// capacity register; the user must write it only while idle, the block does not enforce it
	logic [CAP_W-1:0] cap_q;

	// command and status between controller and datapath
	lkvc_cmd_t cmd;
	lkvc_sts_t sts;
	logic      in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sequencing of scan, decision, update and response load
	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// entry ram, valid bits, trackers and response register
	lkvc_datapath #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cap       (cap_q),
		.req_opcode(req.opcode),
		.req_key   (req.lookup_key),
		.req_value (req.store_value),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_hit   (rsp.hit),
		.out_value (rsp.read_value)
	);

	assign req.ready = in_ready;

endmodule

FILE: sim/tb.sv
// self-checking testbench of the lru key-value cache core
`timescale 1ns / 1ps

module tb;
	import lkvc_pkg::*;

	localparam int ENTRIES = 16;
	// longest request: scan pass, decision, update pass, response load
	localparam int REQ_CYCLES = 2 * ENTRIES + 7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 103;
	// receiver hold-off long enough to back the block up into its request port
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic                     opcode;
		logic signed [KEY_W-1:0]  lookup_key;
		logic signed [DATA_W-1:0] store_value;
	} cache_req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} cache_rsp_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// lru cache mirror plus the responses it owes, oldest first
	class cache_scoreboard;
		bit                    entry_used[ENTRIES];
		logic [KEY_W-1:0]      entry_tag[ENTRIES];
		logic [DATA_W-1:0]     entry_val[ENTRIES];
		int unsigned           entry_rank[ENTRIES];
		int unsigned           fill_count;
		logic [CAP_W-1:0]      capacity;
		cache_rsp_t            owed_responses[$];
		int                    mismatches;
		int                    requests;
		int                    gets;
		int                    hits;
		int                    evictions;

		function new();
			foreach (entry_used[i]) entry_used[i] = 1'b0;
			fill_count = 0;
			capacity = CAP_RESET;
			mismatches = 0;
			requests = 0;
			gets = 0;
			hits = 0;
			evictions = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		// zero acts as one, anything above the entry count saturates
		function int unsigned usable_entries();
			if (capacity == 0)
				return 1;
			if (capacity > ENTRIES)
				return ENTRIES;
			return int'(capacity);
		endfunction

		function int outstanding();
			return owed_responses.size();
		endfunction

		// entry e becomes rank 0, valid entries newer than old_rank age by one
		function void make_newest(int e, int unsigned old_rank);
			for (int i = 0; i < ENTRIES; i++) begin
				if (i != e && entry_used[i] && entry_rank[i] < old_rank)
					entry_rank[i]++;
			end
			entry_rank[e] = 0;
		endfunction

		function int find_tag(logic [KEY_W-1:0] k);
			for (int i = 0; i < ENTRIES; i++) begin
				if (entry_used[i] && entry_tag[i] == k)
					return i;
			end
			return -1;
		endfunction

		function void note_request(cache_req_t r);
			cache_rsp_t  exp;
			int          e;
			int          slot;
			int unsigned worst;
			e = find_tag(r.lookup_key);
			exp.hit = (e >= 0);
			exp.read_value = '0;
			requests++;
			if (r.opcode == OP_GET) begin
				gets++;
				if (e >= 0) begin
					exp.read_value = entry_val[e];
					make_newest(e, entry_rank[e]);
				end
			end else if (e >= 0) begin
				entry_val[e] = r.store_value;
				make_newest(e, entry_rank[e]);
			end else begin
				slot = -1;
				if (fill_count < usable_entries()) begin
					for (int i = 0; i < ENTRIES; i++)
						if (!entry_used[i] && slot < 0)
							slot = i;
				end
				if (slot >= 0) begin
					entry_used[slot] = 1'b1;
					entry_tag[slot] = r.lookup_key;
					entry_val[slot] = r.store_value;
					fill_count++;
					make_newest(slot, ENTRIES);
				end else begin
					worst = 0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (entry_used[i] && (slot < 0 || entry_rank[i] > worst)) begin
							slot = i;
							worst = entry_rank[i];
						end
					end
					if (slot >= 0) begin
						entry_tag[slot] = r.lookup_key;
						entry_val[slot] = r.store_value;
						make_newest(slot, worst);
						evictions++;
					end
				end
			end
			if (exp.hit)
				hits++;
			owed_responses.push_back(exp);
		endfunction

		function void check_response(logic hit, logic signed [DATA_W-1:0] value);
			cache_rsp_t exp;
			if (owed_responses.size() == 0) begin
				$display("%0t: unexpected response, expected none, got hit %0d read_value %0d",
					$time, hit, value);
				mismatches++;
				return;
			end
			exp = owed_responses.pop_front();
			if (hit !== exp.hit) begin
				$display("%0t: hit mismatch, expected %0d, got %0d", $time, exp.hit, hit);
				mismatches++;
			end
			if (value !== exp.read_value) begin
				$display("%0t: read_value mismatch, expected %0d, got %0d",
					$time, exp.read_value, value);
				mismatches++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	lkvc_req_if req ();
	lkvc_rsp_if rsp ();

	lru_key_value_cache_core #(.MAX_ENTRIES(ENTRIES)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cache_scoreboard sb = new();

	// handshake idling pattern of the current phase, read by both sides
	idle_mode_t idle_mode = IDLE_NONE;
	// main flow asks the response side for a long hold-off through this
	int         hold_request = 0;
	int         cap_writes = 0;

	// capacity and idling pattern of each random phase; the 8 gets replaced
	// by a random mid-range value at run time
	logic [CAP_W-1:0] phase_cap[PHASES] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd3, 5'd17, 5'd8, 5'd16};
	idle_mode_t       phase_idle[PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
		IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int send_idle_pct();
		case (idle_mode)
			IDLE_SEND: return 63;
			IDLE_BOTH: return 33;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (idle_mode)
			IDLE_RECV: return 63;
			IDLE_BOTH: return 33;
			default:   return 0;
		endcase
	endfunction

	function automatic cache_req_t mk_req(logic op, logic [KEY_W-1:0] key,
		logic [DATA_W-1:0] val);
		cache_req_t r;
		r.opcode = op;
		r.lookup_key = key;
		r.store_value = val;
		return r;
	endfunction

	// random words half the time, else the signed extremes, all ones or zero
	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// response side: random stalls, plus the long hold-off counted down here
	initial begin
		int hold_left;
		hold_left = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp.ready = 1'b0;
				hold_left--;
			end else begin
				rsp.ready = ($urandom_range(99) >= recv_stall_pct());
			end
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready)
				sb.check_response(rsp.hit, rsp.read_value);
		end
	end

	// offer one request from a falling edge; valid stays high afterwards so
	// back-to-back transactions keep it up without a glitch
	task automatic send_request(input cache_req_t r);
		if ($urandom_range(99) < send_idle_pct()) begin
			req.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct());
		end
		req.valid = 1'b1;
		req.opcode = r.opcode;
		req.lookup_key = r.lookup_key;
		req.store_value = r.store_value;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_request(r);
		@(negedge clk);
	endtask

	// stop offering and wait for every owed response
	task automatic wait_drained();
		req.valid = 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// capacity writes only land on an idle block
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		wait_drained();
		repeat (REQ_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = c;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_capacity(c);
		cap_writes++;
	endtask

	// random traffic over a key pool sized to the capacity so that hits,
	// updates and evictions all occur; a few keys come from outside the pool
	task automatic run_phase(input logic [CAP_W-1:0] c, input idle_mode_t mode,
		input bit squeeze);
		logic [KEY_W-1:0] key_pool[$];
		int               pool_size;
		cache_req_t       r;
		write_capacity(c);
		idle_mode = mode;
		pool_size = sb.usable_entries() + 6;
		key_pool = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
		while (key_pool.size() < pool_size)
			key_pool.push_back($urandom);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// long response hold-off while requests keep coming
			if (squeeze && i == PHASE_ITEMS / 3)
				hold_request = LONG_HOLD;
			// sender pause until the block has answered everything
			if (squeeze && i == 2 * PHASE_ITEMS / 3)
				wait_drained();
			r.opcode = $urandom_range(1) ? OP_PUT : OP_GET;
			if ($urandom_range(9) == 0)
				r.lookup_key = $urandom;
			else
				r.lookup_key = key_pool[$urandom_range(key_pool.size() - 1)];
			r.store_value = pick_word();
			send_request(r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.opcode = OP_GET;
		req.lookup_key = '0;
		req.store_value = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty lookup, extreme keys and values, update, get hit
		send_request(mk_req(OP_GET, 32'h0000_0000, 32'h1111_1111));
		send_request(mk_req(OP_PUT, 32'h8000_0000, 32'h7fff_ffff));
		send_request(mk_req(OP_PUT, 32'h7fff_ffff, 32'h8000_0000));
		send_request(mk_req(OP_PUT, 32'hffff_ffff, 32'hffff_ffff));
		send_request(mk_req(OP_PUT, 32'h0000_0000, 32'h0000_0000));
		send_request(mk_req(OP_GET, 32'h8000_0000, 32'h0));
		send_request(mk_req(OP_GET, 32'h7fff_ffff, 32'hffff_ffff));
		send_request(mk_req(OP_GET, 32'hffff_ffff, 32'h0));
		send_request(mk_req(OP_PUT, 32'hffff_ffff, 32'h1234_5678));
		send_request(mk_req(OP_GET, 32'hffff_ffff, 32'h0));
		send_request(mk_req(OP_GET, 32'h0000_0005, 32'h0));
		send_request(mk_req(OP_GET, 32'h0000_0000, 32'h0));

		// capacity below occupancy: put misses replace the least recent entry
		write_capacity(5'd2);
		send_request(mk_req(OP_PUT, 32'd100, 32'd1));
		send_request(mk_req(OP_GET, 32'h8000_0000, 32'h0));
		send_request(mk_req(OP_PUT, 32'h7fff_ffff, 32'd7));
		send_request(mk_req(OP_PUT, 32'd200, 32'd2));
		send_request(mk_req(OP_GET, 32'hffff_ffff, 32'h0));
		send_request(mk_req(OP_GET, 32'd100, 32'h0));

		// zero capacity behaves as one
		write_capacity(5'd0);
		send_request(mk_req(OP_PUT, 32'd300, 32'd3));
		send_request(mk_req(OP_GET, 32'd300, 32'h0));
		send_request(mk_req(OP_PUT, 32'd400, 32'd4));
		send_request(mk_req(OP_GET, 32'd300, 32'h0));

		phase_cap[6] = CAP_W'($urandom_range(2, 15));
		for (int p = 0; p < PHASES; p++)
			run_phase(phase_cap[p], phase_idle[p], p == 3);

		// wrap up once every response is back and the block has settled
		wait_drained();
		repeat (REQ_CYCLES) @(negedge clk);
		$display("covered %0d requests (%0d gets, %0d puts), %0d hits, %0d evictions",
			sb.requests, sb.gets, sb.requests - sb.gets, sb.hits, sb.evictions);
		$display("%0d capacity writes incl. 0, 1, 2, 3, 16, 17 and 31, four idling patterns",
			cap_writes);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("lru_key_value_cache_core regression: pass");
		end else begin
			$display("lru_key_value_cache_core regression: fail");
		end
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout with %0d responses still owed", sb.outstanding());
		$display("lru_key_value_cache_core regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/lkvc_pkg.sv
hdl/lkvc_if.sv
hdl/lkvc_ram.sv
hdl/lkvc_ctrl.sv
hdl/lkvc_datapath.sv
hdl/lru_key_value_cache_core.sv
sim/tb.sv
